// ----- rtl/toeq_pkg.sv -----
// ----------------------------------------------------------------------------
// toeq_pkg
// Shared types and codes for the time-ordered event queue.
// ----------------------------------------------------------------------------
package toeq_pkg;

    localparam int TIME_W = 32;
    localparam int JOB_W  = 16;
    localparam int KIND_W = 3;
    localparam int OCC_W  = 5;
    localparam int STAT_W = 2;
    localparam int DATA_W = 56;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_POP    = 1'b1;

    localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_POPPED   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [JOB_W-1:0]  job;
        logic [TIME_W-1:0] evt_time;
    } entry_t;

    typedef struct packed {
        logic   insert_en;
        logic   pop_en;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

// ----- rtl/toeq_cell.sv -----
// ----------------------------------------------------------------------------
// toeq_cell
// One slot of the sorted queue. Holds an entry; on insert it keeps, takes
// the new entry or takes its lower neighbor; on pop it takes its upper one.
// ----------------------------------------------------------------------------
module toeq_cell (
    input  logic                clk,
    input  toeq_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  logic                prev_gt,
    input  toeq_pkg::entry_t    prev_entry,
    input  toeq_pkg::entry_t    next_entry,
    output toeq_pkg::entry_t    entry,
    output logic                gt
);
    import toeq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // free slots count as later than any key, so the flag is monotonic
    assign gt    = !occupied || (entry_reg.evt_time > ctrl.new_entry.evt_time);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert_en)
        begin
            if (prev_gt)
                entry_next = prev_entry;
            else if (gt)
                entry_next = ctrl.new_entry;
        end
        else if (ctrl.pop_en)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- rtl/time_ordered_event_queue_unit.sv -----
// ----------------------------------------------------------------------------
// time_ordered_event_queue_unit
// Bounded event queue kept in time order by a shifting row of cells.
// ----------------------------------------------------------------------------
// Input word: s_tuser selects insert (0) or pop (1); s_tdata carries the
// event time, job number and kind. Every input word gives one output word:
// m_tuser is the status (inserted, full, popped, empty), m_tdata the popped
// event (zero otherwise) and the occupancy after the operation.
// Equal times leave first in, first out. Inserts into a full queue and pops
// from an empty queue leave the store unchanged.
// The output word is registered and appears in the cycle after its input
// word is accepted. One word per cycle is sustained while the receiver
// keeps up: every cell compares its key against the new key at once and
// shifts in the same cycle, and the output register is refilled in the
// cycle it is drained. When the receiver stalls, the held output word
// blocks the next input word until taken. Reset empties the queue and clears m_tvalid.
// ----------------------------------------------------------------------------
module time_ordered_event_queue_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [toeq_pkg::DATA_W-1:0] s_tdata,  // event_time, job_number, event_kind
    input  logic                        s_tuser,  // mode
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [toeq_pkg::DATA_W-1:0] m_tdata,  // out_time, out_job, out_kind, occupancy
    output logic [toeq_pkg::STAT_W-1:0] m_tuser   // status
);
    import toeq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = CW + OCC_W;

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              out_valid_reg;
    logic [STAT_W-1:0] out_status_reg;
    entry_t            out_entry_reg;
    logic [OCC_W-1:0]  out_occ_reg;

    logic              accept;
    logic              is_pop;
    logic              full;
    logic              empty;
    logic [STAT_W-1:0] status;
    logic [EW-1:0]     count_ext;
    cell_ctrl_t        ctrl;

    entry_t            cell_entry [QUEUE_DEPTH];
    logic              cell_gt    [QUEUE_DEPTH];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_pop   = (s_tuser == MODE_POP);
    assign full     = (count_reg == CW'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);

    assign ctrl.insert_en          = accept && !is_pop && !full;
    assign ctrl.pop_en             = accept && is_pop && !empty;
    assign ctrl.new_entry.evt_time = s_tdata[TIME_W-1:0];
    assign ctrl.new_entry.job      = s_tdata[TIME_W+JOB_W-1:TIME_W];
    assign ctrl.new_entry.kind     = s_tdata[TIME_W+JOB_W+KIND_W-1:TIME_W+JOB_W];

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.insert_en)
            count_next = count_reg + 1'b1;
        else if (ctrl.pop_en)
            count_next = count_reg - 1'b1;
    end

    always_comb
    begin
        if (is_pop)
            status = empty ? STAT_EMPTY : STAT_POPPED;
        else
            status = full ? STAT_FULL : STAT_INSERTED;
    end

    assign count_ext = EW'(count_next);

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            logic   occ;
            logic   prev_gt;
            entry_t prev_entry;
            entry_t next_entry;

            assign occ = (CW'(i) < count_reg);

            if (i == 0)
            begin : g_head
                assign prev_gt    = 1'b0;
                assign prev_entry = '0;
            end
            else
            begin : g_body
                assign prev_gt    = cell_gt[i-1];
                assign prev_entry = cell_entry[i-1];
            end

            if (i == QUEUE_DEPTH - 1)
            begin : g_tail
                assign next_entry = '0;
            end
            else
            begin : g_inner
                assign next_entry = cell_entry[i+1];
            end

            toeq_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (occ),
                .prev_gt    (prev_gt),
                .prev_entry (prev_entry),
                .next_entry (next_entry),
                .entry      (cell_entry[i]),
                .gt         (cell_gt[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_status_reg <= status;
            out_entry_reg  <= ctrl.pop_en ? cell_entry[0] : '0;
            out_occ_reg    <= count_ext[OCC_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_occ_reg, out_entry_reg.kind, out_entry_reg.job,
                       out_entry_reg.evt_time};

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the time-ordered event queue unit.
// A queue of pending words is filled with a short directed run (pop on
// empty, extreme times, jobs and kinds, equal-time ties, filling to full
// and an insert refused) and then with random segments. Each segment leans
// toward inserts, pops or neither, so the store fills and empties. Both sides
// idle at random, with stretches of no idling, and once in a while the
// sender waits until every pending output word has come back. A
// behavioral sorted store predicts every output word, and the monitor
// checks each one field by field.
// ----------------------------------------------------------------------------
module tb_top;

    import toeq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic              mode;
        logic [TIME_W-1:0] evt_time;
        logic [JOB_W-1:0]  job;
        logic [KIND_W-1:0] kind;
        int                gap;
        bit                drain_first;
    } event_req_t;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [TIME_W-1:0] evt_time;
        logic [JOB_W-1:0]  job;
        logic [KIND_W-1:0] kind;
        logic [OCC_W-1:0]  occupancy;
    } event_resp_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;
    logic              s_tuser = MODE_INSERT;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic [STAT_W-1:0] m_tuser;

    event_req_t  pending_events[$];
    event_resp_t expected_resp[$];

    logic [TIME_W-1:0] sorted_time[QUEUE_DEPTH];
    logic [JOB_W-1:0]  sorted_job[QUEUE_DEPTH];
    logic [KIND_W-1:0] sorted_kind[QUEUE_DEPTH];
    int                sorted_count = 0;

    int mismatch_count = 0;
    int src_gap = -1;
    int sink_hold = 0;
    int sink_words = 0;

    time_ordered_event_queue_unit #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // sorted insert, equal times stay in arrival order
    function automatic event_resp_t schedule_event(logic mode, logic [TIME_W-1:0] t,
                                                   logic [JOB_W-1:0] job,
                                                   logic [KIND_W-1:0] kind);
        event_resp_t r;
        int          pos;
        r.status    = STAT_INSERTED;
        r.evt_time  = '0;
        r.job       = '0;
        r.kind      = '0;
        if (mode == MODE_INSERT)
        begin
            if (sorted_count >= QUEUE_DEPTH)
                r.status = STAT_FULL;
            else
            begin
                pos = 0;
                while (pos < sorted_count && sorted_time[pos] <= t)
                    pos++;
                for (int i = sorted_count; i > pos; i--)
                begin
                    sorted_time[i] = sorted_time[i-1];
                    sorted_job[i]  = sorted_job[i-1];
                    sorted_kind[i] = sorted_kind[i-1];
                end
                sorted_time[pos] = t;
                sorted_job[pos]  = job;
                sorted_kind[pos] = kind;
                sorted_count++;
            end
        end
        else if (sorted_count == 0)
            r.status = STAT_EMPTY;
        else
        begin
            r.status   = STAT_POPPED;
            r.evt_time = sorted_time[0];
            r.job      = sorted_job[0];
            r.kind     = sorted_kind[0];
            for (int i = 1; i < sorted_count; i++)
            begin
                sorted_time[i-1] = sorted_time[i];
                sorted_job[i-1]  = sorted_job[i];
                sorted_kind[i-1] = sorted_kind[i];
            end
            sorted_count--;
        end
        r.occupancy = OCC_W'(sorted_count);
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
        end
    endtask

    task automatic queue_word(logic mode, logic [TIME_W-1:0] t, logic [JOB_W-1:0] job,
                              logic [KIND_W-1:0] kind, int gap, bit drain_first);
        event_req_t e;
        e.mode        = mode;
        e.evt_time    = t;
        e.job         = job;
        e.kind        = kind;
        e.gap         = gap;
        e.drain_first = drain_first;
        pending_events.push_back(e);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= MODE_INSERT;
            src_gap  = -1;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (src_gap < 0 && pending_events.size() != 0)
                src_gap = pending_events[0].gap;
            if (pending_events.size() == 0)
                s_tvalid <= 1'b0;
            else if (src_gap > 0)
            begin
                src_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_events[0].drain_first && (s_tvalid || expected_resp.size() != 0))
                s_tvalid <= 1'b0;
            else
            begin
                s_tvalid <= 1'b1;
                s_tuser  <= pending_events[0].mode;
                s_tdata  <= {5'b0, pending_events[0].kind, pending_events[0].job,
                             pending_events[0].evt_time};
                void'(pending_events.pop_front());
                src_gap = -1;
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            sink_hold = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                sink_words++;
                sink_hold = ((sink_words / 64) % 2 == 0) ? 0 : $urandom_range(0, 12);
            end
            if (sink_hold > 0)
            begin
                sink_hold--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // monitor: check output words, then predict accepted input words
    always @(posedge clk)
    begin
        event_resp_t exp_r;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_resp.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected word expected none actual %0h/%0h",
                             $time, m_tuser, m_tdata);
                end
                else
                begin
                    exp_r = expected_resp.pop_front();
                    check_field("status", 32'(exp_r.status), 32'(m_tuser));
                    check_field("out_time", exp_r.evt_time, m_tdata[31:0]);
                    check_field("out_job", 32'(exp_r.job), 32'(m_tdata[47:32]));
                    check_field("out_kind", 32'(exp_r.kind), 32'(m_tdata[50:48]));
                    check_field("occupancy", 32'(exp_r.occupancy), 32'(m_tdata[55:51]));
                end
            end
            if (s_tvalid && s_tready)
                expected_resp.push_back(schedule_event(s_tuser, s_tdata[31:0],
                                                       s_tdata[47:32], s_tdata[50:48]));
        end
    end

    initial
    begin : watchdog
        int stuck = 0;
        while (stuck < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stuck = 0;
            else
                stuck++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : stimulus
        int          ins_pct;
        bit          calm;
        logic        mode;
        logic [31:0] t;

        // directed: empty pop, extremes, ties, fill to full, refused insert
        queue_word(MODE_POP, 32'hFFFFFFFF, 16'hFFFF, 3'd7, 0, 1'b0);
        queue_word(MODE_INSERT, 32'd100, 16'd1, 3'd0, 0, 1'b0);
        queue_word(MODE_INSERT, 32'd100, 16'd2, 3'd1, 0, 1'b0);
        queue_word(MODE_INSERT, 32'd0, 16'hFFFF, 3'd4, 0, 1'b0);
        queue_word(MODE_INSERT, 32'hFFFFFFFF, 16'd0, 3'd7, 3, 1'b0);
        queue_word(MODE_INSERT, 32'd100, 16'd3, 3'd5, 0, 1'b0);
        queue_word(MODE_INSERT, 32'd50, 16'd4, 3'd6, 5, 1'b0);
        queue_word(MODE_INSERT, 32'hFFFFFFFF, 16'd5, 3'd2, 0, 1'b0);
        queue_word(MODE_INSERT, 32'd0, 16'd6, 3'd3, 1, 1'b0);
        for (int i = 0; i < 8; i++)
            queue_word(MODE_INSERT, 32'($urandom_range(1, 8)), 16'(100 + i), 3'(i),
                       $urandom_range(0, 2), 1'b0);
        queue_word(MODE_INSERT, 32'd1, 16'hAAAA, 3'd1, 0, 1'b0);
        for (int i = 0; i < 4; i++)
            queue_word(MODE_POP, $urandom, 16'($urandom), 3'($urandom), 0, 1'b0);

        // random segments, alternating insert bias and idling style
        for (int seg = 0; seg < 10; seg++)
        begin
            ins_pct = (seg % 3 == 0) ? 80 : ((seg % 3 == 1) ? 50 : 20);
            calm    = (seg % 2 == 0);
            for (int i = 0; i < 50; i++)
            begin
                mode = ($urandom_range(0, 99) < ins_pct) ? MODE_INSERT : MODE_POP;
                case ($urandom_range(0, 3))
                    0, 1:    t = $urandom_range(0, 15);
                    2:       t = $urandom;
                    default: t = 32'hFFFFFFFF - $urandom_range(0, 3);
                endcase
                queue_word(mode, t, 16'($urandom), 3'($urandom_range(0, 7)),
                           calm ? 0 : $urandom_range(0, 12),
                           (i == 0) && (seg == 4 || seg == 8));
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_events.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_resp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
